### sv/rbds_pkg.sv
package rbds_pkg;

   // image geometry
   localparam int MAX_OUT_SIDE = 512;
   localparam int SIDE_W       = 10;
   localparam int ADDR_W       = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;

   // pixel packing: four 8-bit channels, red first
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 4;
   localparam int PIX_W   = CH_W * NUM_CH;
   localparam int LANE_W  = CH_W + 1;
   localparam int WORD_W  = LANE_W * NUM_CH;

   typedef logic [WORD_W-1:0] word_type;

   // read request handed from the control stage to the averaging stage
   typedef struct packed {
      logic     load;
      logic     frame_end;
      word_type pair;
   } rbds_rd_type;

   // clamp the configured side into 1..MAX_OUT_SIDE
   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] r;
      if (side == '0) begin
         r = SIDE_W'(1);
      end else if (32'(side) > MAX_OUT_SIDE) begin
         r = SIDE_W'(MAX_OUT_SIDE);
      end else begin
         r = side;
      end
      return r;
   endfunction

   // widen a pixel into four 9-bit lanes
   function automatic word_type pix_to_word(input logic [PIX_W-1:0] pix);
      word_type w;
      for (int c = 0; c < NUM_CH; c++) begin
         w[c*LANE_W +: LANE_W] = {1'b0, pix[c*CH_W +: CH_W]};
      end
      return w;
   endfunction

   // lane-wise add, no carry between lanes
   function automatic word_type lane_add(input word_type a, input word_type b);
      word_type r;
      for (int c = 0; c < NUM_CH; c++) begin
         r[c*LANE_W +: LANE_W] = a[c*LANE_W +: LANE_W] + b[c*LANE_W +: LANE_W];
      end
      return r;
   endfunction

endpackage

### sv/rgba_box_downsample_2x2.sv
// 2x2 box-filter downsampler for RGBA8. Source pixels of a square image, twice
// csr_wdata pixels on a side, enter in raster order, one word per clock. Each
// output word is the per-channel average of a 2x2 block, truncated, and the
// last word of the image carries rsp_tlast. Pair sums of even rows are kept in
// a one-row line store (single RAM, one access per pixel pair); odd rows read
// them back. An output word passes through the line-store read register and
// then the output register. The input takes one word per clock; it stalls
// only when both the read stage and the output register hold blocks the
// consumer has not taken. The user must write the side (1..512, reset 512)
// on csr_we only while no pixel is in flight; the block does not enforce this.
module rgba_box_downsample_2x2
   import rbds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIDE_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // red_in, green_in, blue_in, alpha_in
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   output logic              rsp_tlast
);

   logic              accept;
   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_addr;
   word_type          ram_wdata;
   word_type          ram_rdata;
   rbds_rd_type       rd;

   assign accept = req_tvalid && req_tready;

   // counters, pair sums and line-store addressing
   rbds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .pixel     (req_tdata),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .rd        (rd)
   );

   // line store of even-row pair sums
   rbds_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_OUT_SIDE)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // block average and output register
   rbds_avg u_avg (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd),
      .ram_rdata (ram_rdata),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

### sv/rbds_ram.sv
module rbds_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 512
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/rbds_ctrl.sv
module rbds_ctrl
   import rbds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIDE_W-1:0] csr_wdata,
   input  logic              accept,
   input  logic [PIX_W-1:0]  pixel,
   output logic              ram_we,
   output logic              ram_re,
   output logic [ADDR_W-1:0] ram_addr,
   output word_type          ram_wdata,
   output rbds_rd_type       rd
);

   logic [SIDE_W-1:0] side_ff, side_in;
   word_type          hold_ff, hold_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic              col_odd_ff, col_odd_in;
   logic              row_odd_ff, row_odd_in;

   logic [SIDE_W-1:0] side;
   logic [SIDE_W-1:0] col_eff;
   logic              last_col;
   logic              last_row;
   logic              pair_step;
   word_type          pix_word;
   word_type          pair;

   // clamped side and column
   assign side     = eff_side(side_ff);
   assign col_eff  = (col_ff >= side) ? side - SIDE_W'(1) : col_ff;
   assign last_col = ({1'b0, col_eff} + (SIDE_W+1)'(1)) >= {1'b0, side};
   assign last_row = ({1'b0, row_ff} + (SIDE_W+1)'(1)) >= {1'b0, side};

   assign pix_word  = pix_to_word(pixel);
   assign pair      = lane_add(hold_ff, pix_word);
   assign pair_step = accept && col_odd_ff;

   // line store access on the second pixel of a pair
   assign ram_addr     = ADDR_W'(col_eff);
   assign ram_wdata    = pair;
   assign ram_we       = pair_step && !row_odd_ff;
   assign ram_re       = pair_step && row_odd_ff;
   assign rd.load      = ram_re;
   assign rd.frame_end = last_col && last_row;
   assign rd.pair      = pair;

   // position counters
   always_comb begin
      side_in    = csr_we ? csr_wdata : side_ff;
      hold_in    = hold_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      col_odd_in = col_odd_ff;
      row_odd_in = row_odd_ff;
      if (accept) begin
         col_in = col_eff;
         if (!col_odd_ff) begin
            hold_in    = pix_word;
            col_odd_in = 1'b1;
         end else begin
            col_odd_in = 1'b0;
            if (last_col) begin
               col_in = '0;
               if (row_odd_ff) begin
                  row_odd_in = 1'b0;
                  row_in     = last_row ? '0 : row_ff + SIDE_W'(1);
               end else begin
                  row_odd_in = 1'b1;
               end
            end else begin
               col_in = col_eff + SIDE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= SIDE_W'(MAX_OUT_SIDE);
         hold_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         col_odd_ff <= 1'b0;
         row_odd_ff <= 1'b0;
      end else begin
         side_ff    <= side_in;
         hold_ff    <= hold_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_odd_ff <= col_odd_in;
         row_odd_ff <= row_odd_in;
      end
   end

   // line store is either written or read by one word, never both
   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("line store read and write in one cycle");

   // a pair completes and the column phase returns to even
   a_pair_phase: assert property (@(posedge clock) disable iff (reset)
      pair_step |=> !col_odd_ff)
      else $error("column phase did not return after pair");

   // a block end on an odd row moves to the next even row
   a_row_turn: assert property (@(posedge clock) disable iff (reset)
      (ram_re && last_col) |=> !row_odd_ff)
      else $error("row phase did not advance at end of odd row");

endmodule

### sv/rbds_avg.sv
module rbds_avg
   import rbds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rbds_rd_type       rd,
   input  word_type          ram_rdata,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [PIX_W-1:0]  out_pixel,
   output logic              out_last
);

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_last_ff;
   word_type         s1_pair_ff;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_pixel_ff;
   logic             out_last_ff;

   logic             s1_move;
   logic [PIX_W-1:0] avg;

   // stage 1 drains into the output register when that is free or taken
   assign s1_move     = s1_valid_ff && (!out_valid_ff || out_ready);
   assign s1_valid_in = rd.load || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !out_ready);

   // take input unless both the read stage and the output register are full
   assign in_ready = !(s1_valid_ff && out_valid_ff);

   // four-pixel sum per lane, divided by four
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         avg[c*CH_W +: CH_W] = 8'(({1'b0, ram_rdata[c*LANE_W +: LANE_W]}
                                  + {1'b0, s1_pair_ff[c*LANE_W +: LANE_W]}) >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rd.load) begin
         s1_pair_ff <= rd.pair;
         s1_last_ff <= rd.frame_end;
      end
      if (s1_move) begin
         out_pixel_ff <= avg;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_last  = out_last_ff;

   // a new read never lands on a block that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rd.load |-> (!s1_valid_ff || s1_move))
      else $error("read stage overwritten");

   // a waiting block moves on as soon as the output register is empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("read stage did not drain");

   // a block held in the output register is not dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff)
      else $error("output word dropped");

endmodule
